// File: rtl/core/swm_pkg.sv
// swm_pkg: shared constants for the sliding window maximum block
// used by the channel interfaces, the core and the checker
`default_nettype none

package swm_pkg;

  localparam int unsigned MAX_WINDOW_DEF   = 64;
  localparam int unsigned SAMPLE_WIDTH_DEF = 32;
  localparam int unsigned CFG_WIDTH        = 7;

endpackage

`default_nettype wire

// File: rtl/core/swm_if.sv
// swm_in_if / swm_out_if: valid/ready channels for sample words and max words
// depends on swm_pkg for the default sample width
`default_nettype none

interface swm_in_if
  import swm_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           new_sequence;

  modport source (output valid, output sample, output new_sequence, input ready);
  modport sink   (input valid, input sample, input new_sequence, output ready);
endinterface

interface swm_out_if
  import swm_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] window_max;

  modport source (output valid, output window_max, input ready);
  modport sink   (input valid, input window_max, output ready);
endinterface

`default_nettype wire

// File: rtl/core/swm_ram.sv
// swm_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module swm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sliding_window_maximum.sv
// sliding_window_maximum: maximum over a sliding window of signed samples
// Usage:
//   in_i   carries one sample word with a new_sequence flag (valid/ready).
//   out_o  carries one window_max word per sample once the window has filled
//          (window_size samples of the current sequence seen); earlier samples
//          of a sequence give no word.
//   cfg_we_i/cfg_wdata_i write window_size; 0 acts as 1, above MAX_WINDOW acts
//   as MAX_WINDOW. Write it only while the block is idle.
// Timing:
//   The candidate queue lives in one ram with a single registered read port,
//   and every queue compare waits on that port. After a sample is taken
//   in_i.ready stays low through the tail reads and compares, the head reads
//   and compares that drop stale heads, the append and, when a word is due,
//   the output read and load; the tail and head checks are skipped when the
//   queue is empty. Each sample is popped or dropped at most once. The result
//   shows on out_o in the cycle after the last step.
// Reset: rst_ni clears the queue, the position and the fill count, and sets
//   window_size to 1. Queue ram contents are not cleared.
// Stall: a finished word waits in the output register; the next sample is
//   still taken and worked on, and only its final load waits for out_o.ready.
`default_nettype none

module sliding_window_maximum
  import swm_pkg::*;
#(
  parameter int unsigned MAX_WINDOW   = MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_WIDTH-1:0] cfg_wdata_i,
  swm_in_if.sink                    in_i,
  swm_out_if.source                 out_o
);

  localparam int unsigned AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned KW    = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SW    = KW + 1;
  localparam int unsigned POS_W = KW + 1;
  localparam int unsigned RAM_W = POS_W + SAMPLE_WIDTH;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_TAIL_RD  = 3'd1;
  localparam logic [2:0] S_TAIL_CMP = 3'd2;
  localparam logic [2:0] S_HEAD_RD  = 3'd3;
  localparam logic [2:0] S_HEAD_CMP = 3'd4;
  localparam logic [2:0] S_APPEND   = 3'd5;
  localparam logic [2:0] S_OUT_RD   = 3'd6;
  localparam logic [2:0] S_OUT      = 3'd7;

  logic [2:0]                    state_q, state_d;
  logic [AW-1:0]                 head_q, head_d;
  logic [KW-1:0]                 count_q, count_d;
  logic [KW-1:0]                 fill_q, fill_d;
  logic [POS_W-1:0]              spos_q, spos_d;
  logic [POS_W-1:0]              cur_pos_q, cur_pos_d;
  logic signed [SAMPLE_WIDTH-1:0] cur_val_q, cur_val_d;
  logic [CFG_WIDTH-1:0]          win_q;
  logic                          out_valid_q, out_valid_d;
  logic signed [SAMPLE_WIDTH-1:0] out_data_q, out_data_d;

  logic [KW-1:0]                 win_k;
  logic                          ram_we, ram_re;
  logic [AW-1:0]                 ram_waddr, ram_raddr;
  logic [RAM_W-1:0]              ram_rdata;
  logic signed [SAMPLE_WIDTH-1:0] rd_val;
  logic [POS_W-1:0]              rd_pos;
  logic [POS_W-1:0]              age;
  logic [KW-1:0]                 fill_next;

  // (head + off) mod MAX_WINDOW, with off at most MAX_WINDOW
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] head,
                                             input logic [KW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(off);
    if (sum >= SW'(MAX_WINDOW)) begin
      sum = sum - SW'(MAX_WINDOW);
    end
    return sum[AW-1:0];
  endfunction

  always_comb begin
    if (win_q == '0) begin
      win_k = KW'(1);
    end else if (32'(win_q) > 32'(MAX_WINDOW)) begin
      win_k = KW'(MAX_WINDOW);
    end else begin
      win_k = KW'(win_q);
    end
  end

  assign rd_val    = ram_rdata[SAMPLE_WIDTH-1:0];
  assign rd_pos    = ram_rdata[RAM_W-1:SAMPLE_WIDTH];
  assign age       = cur_pos_q - rd_pos;
  assign fill_next = (fill_q < KW'(MAX_WINDOW)) ? fill_q + KW'(1) : fill_q;

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.window_max = out_data_q;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    fill_d      = fill_q;
    spos_d      = spos_q;
    cur_pos_d   = cur_pos_q;
    cur_val_d   = cur_val_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = ring_add(head_q, count_q);
    ram_raddr   = head_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          cur_val_d = in_i.sample;
          if (in_i.new_sequence) begin
            count_d   = '0;
            fill_d    = '0;
            cur_pos_d = '0;
          end else begin
            cur_pos_d = spos_q;
          end
          state_d = S_TAIL_RD;
        end
      end
      S_TAIL_RD: begin
        if (count_q == '0) begin
          state_d = S_HEAD_RD;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ring_add(head_q, count_q - KW'(1));
          state_d   = S_TAIL_CMP;
        end
      end
      S_TAIL_CMP: begin
        // strictly smaller tail entries can never be the max again
        if (rd_val < cur_val_q) begin
          count_d = count_q - KW'(1);
          state_d = S_TAIL_RD;
        end else begin
          state_d = S_HEAD_RD;
        end
      end
      S_HEAD_RD: begin
        if (count_q == '0) begin
          state_d = S_APPEND;
        end else begin
          ram_re  = 1'b1;
          state_d = S_HEAD_CMP;
        end
      end
      S_HEAD_CMP: begin
        if (age >= POS_W'(win_k)) begin
          head_d  = ring_add(head_q, KW'(1));
          count_d = count_q - KW'(1);
          state_d = S_HEAD_RD;
        end else begin
          state_d = S_APPEND;
        end
      end
      S_APPEND: begin
        ram_we = 1'b1;
        // a full queue drops its head; the write slot is the same either way
        if (count_q >= KW'(MAX_WINDOW)) begin
          head_d = ring_add(head_q, KW'(1));
        end else begin
          count_d = count_q + KW'(1);
        end
        spos_d = cur_pos_q + POS_W'(1);
        fill_d = fill_next;
        if (fill_next >= win_k) begin
          state_d = S_OUT_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_OUT_RD: begin
        ram_re  = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = rd_val;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      fill_q      <= '0;
      spos_q      <= '0;
      win_q       <= CFG_WIDTH'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      fill_q      <= fill_d;
      spos_q      <= spos_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        win_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_pos_q  <= cur_pos_d;
    cur_val_q  <= cur_val_d;
    out_data_q <= out_data_d;
  end

  swm_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_WINDOW)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({cur_pos_q, cur_val_q}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

// File: rtl/core/swm_checker.sv
// swm_checker: port level assertions for sliding_window_maximum, bound to the top
// depends on swm_pkg for the default sample width
`default_nettype none

module swm_checker
  import swm_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_ready_i,
  input wire logic                    out_valid_i,
  input wire logic                    out_ready_i,
  input wire logic [SAMPLE_WIDTH-1:0] out_max_i
);

  // a word held on the output stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_max_i))
    else $error("output word changed while stalled");

  // a sample's work keeps the block busy, so input closes right after a transfer
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after a transfer");

  // a new result is loaded only at the end of a sample's work
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared while idle");

endmodule

bind sliding_window_maximum swm_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_max_i   (out_o.window_max)
);

`default_nettype wire

// File: bench/tb_sliding_window_maximum.sv
// tb_sliding_window_maximum: checks sliding_window_maximum word by word against
// a behavioral candidate-queue predictor; needs swm_pkg, swm_if and the rtl
// directed corner words first, then random runs over a range of window sizes
module tb_sliding_window_maximum;
  timeunit 1ns;
  timeprecision 1ps;
  import swm_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int unsigned PHASE_WORDS = 72;
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};

  typedef struct {
    logic signed [SW-1:0] sample;
    logic                 new_sequence;
  } sample_word_t;

  typedef enum int {
    RUN_SCATTER, RUN_NEAR_ZERO, RUN_RISING, RUN_FALLING, RUN_EXTREME
  } run_shape_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_WIDTH-1:0] cfg_wdata_i = '0;

  swm_in_if #(.SAMPLE_WIDTH(SW)) in_if ();
  swm_out_if #(.SAMPLE_WIDTH(SW)) out_if ();

  sliding_window_maximum uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state: candidate values and positions, oldest at cand_head
  logic signed [SW-1:0] cand_val [MAX_WINDOW_DEF];
  logic [31:0]          cand_pos [MAX_WINDOW_DEF];
  int unsigned          cand_head = 0;
  int unsigned          cand_count = 0;
  int unsigned          seen_count = 0;
  logic [31:0]          seq_pos = '0;
  logic [CFG_WIDTH-1:0] window_reg = CFG_WIDTH'(1);

  sample_word_t         pending_words [$];
  logic signed [SW-1:0] expected_max [$];
  sample_word_t         next_word;
  bit                   has_max;
  logic signed [SW-1:0] next_max;
  logic signed [SW-1:0] want_max;
  int unsigned          gap_left = 0;
  int unsigned          stall_left = 0;
  bit                   src_busy = 1'b0;
  bit                   sink_busy = 1'b0;
  int unsigned          fail_count = 0;
  int unsigned          cycle_count = 0;

  function automatic int unsigned span_of(logic [CFG_WIDTH-1:0] w);
    if (w == 0) return 1;
    if (w > MAX_WINDOW_DEF) return MAX_WINDOW_DEF;
    return 32'(w);
  endfunction

  function automatic void slide_window(input logic signed [SW-1:0] s, input logic fresh,
                                       output bit emits, output logic signed [SW-1:0] wmax);
    int unsigned span;
    logic [31:0] at;
    span = span_of(window_reg);
    if (fresh) begin
      cand_count = 0;
      seq_pos = '0;
      seen_count = 0;
    end
    at = seq_pos;
    // equal values stay, only strictly smaller ones leave the tail
    while (cand_count > 0 &&
           cand_val[(cand_head + cand_count - 1) % MAX_WINDOW_DEF] < s)
      cand_count--;
    // ages wrap with the 32-bit position
    while (cand_count > 0 && (at - cand_pos[cand_head]) >= span) begin
      cand_head = (cand_head + 1) % MAX_WINDOW_DEF;
      cand_count--;
    end
    if (cand_count >= MAX_WINDOW_DEF) begin
      cand_head = (cand_head + 1) % MAX_WINDOW_DEF;
      cand_count--;
    end
    cand_val[(cand_head + cand_count) % MAX_WINDOW_DEF] = s;
    cand_pos[(cand_head + cand_count) % MAX_WINDOW_DEF] = at;
    cand_count++;
    seq_pos = at + 1;
    if (seen_count < MAX_WINDOW_DEF) seen_count++;
    emits = (seen_count >= span);
    wmax = cand_val[cand_head];
  endfunction

  // sender: one word at a time from pending_words, random gaps between words when src_busy is set
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.sample <= '0;
      in_if.new_sequence <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        slide_window(in_if.sample, in_if.new_sequence, has_max, next_max);
        if (has_max) expected_max.insert(expected_max.size(), next_max);
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          next_word = pending_words[0];
          pending_words.delete(0);
          in_if.valid <= 1'b1;
          in_if.sample <= next_word.sample;
          in_if.new_sequence <= next_word.new_sequence;
          gap_left = src_busy ? $urandom_range(0, 15) : 0;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: compare each word with the oldest expected maximum
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_max.size() == 0) begin
          $error("unexpected window_max word: actual %0d", out_if.window_max);
          fail_count++;
        end else begin
          want_max = expected_max[0];
          expected_max.delete(0);
          if (out_if.window_max !== want_max) begin
            $error("window_max mismatch: expected %0d, actual %0d", want_max,
                   out_if.window_max);
            fail_count++;
          end
        end
        stall_left = sink_busy ? $urandom_range(0, 15) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_if.ready <= (stall_left == 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic queue_word(logic signed [SW-1:0] s, logic fresh);
    sample_word_t w;
    w.sample = s;
    w.new_sequence = fresh;
    pending_words.insert(pending_words.size(), w);
  endtask

  // waits until every queued word is sent and every expected word is back, then lets the core go quiet
  task automatic settle();
    do @(negedge clk_i);
    while (pending_words.size() != 0 || in_if.valid || gap_left != 0 ||
           expected_max.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_window(logic [CFG_WIDTH-1:0] w);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    window_reg = w;
    @(negedge clk_i);
  endtask

  initial begin
    logic [CFG_WIDTH-1:0] phase_window [14];
    int unsigned          eff;
    int unsigned          made;
    int unsigned          run_len;
    run_shape_e           shape;
    logic signed [SW-1:0] base;
    logic signed [SW-1:0] val;
    int                   step;
    int                   near;
    logic                 fresh;

    phase_window = '{2, 5, 64, 1, 127, 3, 0, 65, 16, 8, 4, 33, 1, 7};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // window of one straight from reset: every word is its own maximum
    queue_word(S_MIN, 1'b1);
    queue_word(S_MAX, 1'b0);
    queue_word(-1, 1'b0);
    queue_word(0, 1'b0);
    settle();

    // equal values kept, extremes, then stale heads leaving one at a time
    write_window(3);
    queue_word(5, 1'b1);
    queue_word(5, 1'b0);
    queue_word(5, 1'b0);
    queue_word(7, 1'b0);
    queue_word(S_MIN, 1'b0);
    queue_word(S_MIN, 1'b0);
    queue_word(S_MAX, 1'b0);
    queue_word(3, 1'b0);
    queue_word(2, 1'b0);
    queue_word(1, 1'b0);
    settle();

    // deep falling queue, then the window shrinks with the sequence still open
    write_window(6);
    queue_word(60, 1'b1);
    queue_word(50, 1'b0);
    queue_word(40, 1'b0);
    queue_word(30, 1'b0);
    queue_word(20, 1'b0);
    queue_word(10, 1'b0);
    settle();
    write_window(2);
    queue_word(9, 1'b0);
    queue_word(8, 1'b0);
    settle();

    // zero acts as one
    write_window(0);
    queue_word(42, 1'b1);
    queue_word(-42, 1'b0);
    settle();

    // oversize register clamps; a lone word leaves the window unfilled
    write_window(127);
    queue_word(S_MAX, 1'b1);
    settle();

    foreach (phase_window[p]) begin
      write_window(phase_window[p]);
      eff = span_of(phase_window[p]);
      src_busy = ($urandom_range(0, 2) != 0);
      sink_busy = ($urandom_range(0, 2) != 0);
      made = 0;
      while (made < PHASE_WORDS) begin
        shape = run_shape_e'($urandom_range(0, 4));
        run_len = $urandom_range(1, eff + 8);
        base = $urandom;
        step = $urandom_range(1, 1000);
        for (int i = 0; i < run_len && made < PHASE_WORDS; i++) begin
          fresh = ($urandom_range(0, 3 * eff + 30) == 0);
          case (shape)
            RUN_SCATTER: begin
              val = $urandom;
            end
            RUN_NEAR_ZERO: begin
              near = $urandom_range(0, 6);
              val = near - 3;
            end
            RUN_RISING: begin
              val = base + i * step;
            end
            RUN_FALLING: begin
              val = base - i * step;
            end
            default: begin
              case ($urandom_range(0, 3))
                0: val = S_MIN;
                1: val = S_MAX;
                2: val = 0;
                default: val = -1;
              endcase
            end
          endcase
          queue_word(val, fresh);
          made++;
        end
      end
      settle();
    end

    if (fail_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
